// ===== rtl/qou_pkg.sv =====
// Shared types, constants and tables for the quaternion orientation unit.
// Depends on nothing; every other file in rtl/ refers to it by scoped names.
package qou_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int FRAC_BITS    = 14;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam int CORD_SHIFT   = 30 - FRAC_BITS;
    localparam int TAB_IDX_W    = 5;
    localparam int PC_W         = 6;

    localparam logic signed [34:0] PHASE_PI      = 35'sd3373259426;
    localparam logic signed [34:0] PHASE_HALF_PI = 35'sd1686629713;
    localparam logic signed [33:0] CORDIC_X0     = 34'sd652032874;

    localparam logic [2:0] OP_LOAD  = 3'd0;
    localparam logic [2:0] OP_AXIS  = 3'd1;
    localparam logic [2:0] OP_PYR   = 3'd2;
    localparam logic [2:0] OP_ROT_X = 3'd3;
    localparam logic [2:0] OP_ROT_Y = 3'd4;
    localparam logic [2:0] OP_ROT_Z = 3'd5;
    localparam logic [2:0] OP_MUL   = 3'd6;

    // microprogram start addresses
    localparam logic [PC_W-1:0] PC_LOAD = 6'd0;
    localparam logic [PC_W-1:0] PC_KEEP = 6'd4;
    localparam logic [PC_W-1:0] PC_AXIS = 6'd8;
    localparam logic [PC_W-1:0] PC_PYR  = 6'd12;
    localparam logic [PC_W-1:0] PC_MUL  = 6'd24;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [15:0] angle_a;
        logic signed [15:0] angle_b;
        logic signed [15:0] angle_c;
        logic signed [15:0] in_x;
        logic signed [15:0] in_y;
        logic signed [15:0] in_z;
        logic signed [15:0] in_w;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic signed [15:0] out_z;
        logic signed [15:0] out_w;
    } out_item_t;

    typedef enum logic [4:0] {
        SRC_OX, SRC_OY, SRC_OZ, SRC_OW,
        SRC_RX, SRC_RY, SRC_RZ, SRC_RW,
        SRC_IX, SRC_IY, SRC_IZ, SRC_IW,
        SRC_S0, SRC_C0, SRC_S1, SRC_C1, SRC_S2, SRC_C2,
        SRC_CPCY, SRC_SPSY, SRC_CPSY, SRC_SPCY,
        SRC_ONE
    } src_t;

    typedef enum logic [2:0] {
        DST_RES_X, DST_RES_Y, DST_RES_Z, DST_RES_W,
        DST_CPCY, DST_SPSY, DST_CPSY, DST_SPCY
    } dst_t;

    typedef struct packed {
        src_t a_sel;
        src_t b_sel;
        logic neg;
        logic last;
        dst_t dst;
        logic fin;
    } mac_entry_t;

    typedef struct packed {
        logic            load_in;
        logic            cord_start;
        logic [1:0]      cord_slot;
        logic            rot_load;
        logic [1:0]      rot_axis;
        logic            mac_issue;
        logic [PC_W-1:0] pc;
        logic            commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic cord_done;
    } dp_status_t;

    function automatic mac_entry_t mk(input src_t a, input src_t b, input logic neg,
                                      input logic last, input dst_t dst, input logic fin);
        mac_entry_t e;
        e.a_sel = a;
        e.b_sel = b;
        e.neg   = neg;
        e.last  = last;
        e.dst   = dst;
        e.fin   = fin;
        return e;
    endfunction

    function automatic mac_entry_t mac_prog(input logic [PC_W-1:0] pc);
        mac_entry_t e;
        case (pc)
            // load
            6'd0:  e = mk(SRC_ONE, SRC_IX, 1'b0, 1'b1, DST_RES_X, 1'b0);
            6'd1:  e = mk(SRC_ONE, SRC_IY, 1'b0, 1'b1, DST_RES_Y, 1'b0);
            6'd2:  e = mk(SRC_ONE, SRC_IZ, 1'b0, 1'b1, DST_RES_Z, 1'b0);
            6'd3:  e = mk(SRC_ONE, SRC_IW, 1'b0, 1'b1, DST_RES_W, 1'b1);
            // keep orientation (unused op)
            6'd4:  e = mk(SRC_ONE, SRC_OX, 1'b0, 1'b1, DST_RES_X, 1'b0);
            6'd5:  e = mk(SRC_ONE, SRC_OY, 1'b0, 1'b1, DST_RES_Y, 1'b0);
            6'd6:  e = mk(SRC_ONE, SRC_OZ, 1'b0, 1'b1, DST_RES_Z, 1'b0);
            6'd7:  e = mk(SRC_ONE, SRC_OW, 1'b0, 1'b1, DST_RES_W, 1'b1);
            // axis-angle
            6'd8:  e = mk(SRC_IX, SRC_S0, 1'b0, 1'b1, DST_RES_X, 1'b0);
            6'd9:  e = mk(SRC_IY, SRC_S0, 1'b0, 1'b1, DST_RES_Y, 1'b0);
            6'd10: e = mk(SRC_IZ, SRC_S0, 1'b0, 1'b1, DST_RES_Z, 1'b0);
            6'd11: e = mk(SRC_ONE, SRC_C0, 1'b0, 1'b1, DST_RES_W, 1'b1);
            // pitch-yaw-roll
            6'd12: e = mk(SRC_C0, SRC_C1, 1'b0, 1'b1, DST_CPCY, 1'b0);
            6'd13: e = mk(SRC_S0, SRC_S1, 1'b0, 1'b1, DST_SPSY, 1'b0);
            6'd14: e = mk(SRC_C0, SRC_S1, 1'b0, 1'b1, DST_CPSY, 1'b0);
            6'd15: e = mk(SRC_S0, SRC_C1, 1'b0, 1'b1, DST_SPCY, 1'b0);
            6'd16: e = mk(SRC_S2, SRC_CPCY, 1'b0, 1'b0, DST_RES_X, 1'b0);
            6'd17: e = mk(SRC_C2, SRC_SPSY, 1'b1, 1'b1, DST_RES_X, 1'b0);
            6'd18: e = mk(SRC_C2, SRC_SPCY, 1'b0, 1'b0, DST_RES_Y, 1'b0);
            6'd19: e = mk(SRC_S2, SRC_CPSY, 1'b0, 1'b1, DST_RES_Y, 1'b0);
            6'd20: e = mk(SRC_C2, SRC_CPSY, 1'b0, 1'b0, DST_RES_Z, 1'b0);
            6'd21: e = mk(SRC_S2, SRC_SPCY, 1'b1, 1'b1, DST_RES_Z, 1'b0);
            6'd22: e = mk(SRC_C2, SRC_CPCY, 1'b0, 1'b0, DST_RES_W, 1'b0);
            6'd23: e = mk(SRC_S2, SRC_SPSY, 1'b0, 1'b1, DST_RES_W, 1'b1);
            // Hamilton product on the right
            6'd24: e = mk(SRC_OW, SRC_RW, 1'b0, 1'b0, DST_RES_W, 1'b0);
            6'd25: e = mk(SRC_OX, SRC_RX, 1'b1, 1'b0, DST_RES_W, 1'b0);
            6'd26: e = mk(SRC_OY, SRC_RY, 1'b1, 1'b0, DST_RES_W, 1'b0);
            6'd27: e = mk(SRC_OZ, SRC_RZ, 1'b1, 1'b1, DST_RES_W, 1'b0);
            6'd28: e = mk(SRC_OY, SRC_RZ, 1'b0, 1'b0, DST_RES_X, 1'b0);
            6'd29: e = mk(SRC_OZ, SRC_RY, 1'b1, 1'b0, DST_RES_X, 1'b0);
            6'd30: e = mk(SRC_OW, SRC_RX, 1'b0, 1'b0, DST_RES_X, 1'b0);
            6'd31: e = mk(SRC_OX, SRC_RW, 1'b0, 1'b1, DST_RES_X, 1'b0);
            6'd32: e = mk(SRC_OZ, SRC_RX, 1'b0, 1'b0, DST_RES_Y, 1'b0);
            6'd33: e = mk(SRC_OX, SRC_RZ, 1'b1, 1'b0, DST_RES_Y, 1'b0);
            6'd34: e = mk(SRC_OW, SRC_RY, 1'b0, 1'b0, DST_RES_Y, 1'b0);
            6'd35: e = mk(SRC_OY, SRC_RW, 1'b0, 1'b1, DST_RES_Y, 1'b0);
            6'd36: e = mk(SRC_OX, SRC_RY, 1'b0, 1'b0, DST_RES_Z, 1'b0);
            6'd37: e = mk(SRC_OY, SRC_RX, 1'b1, 1'b0, DST_RES_Z, 1'b0);
            6'd38: e = mk(SRC_OW, SRC_RZ, 1'b0, 1'b0, DST_RES_Z, 1'b0);
            6'd39: e = mk(SRC_OZ, SRC_RW, 1'b0, 1'b1, DST_RES_Z, 1'b1);
            default: e = mk(SRC_ONE, SRC_OX, 1'b0, 1'b1, DST_RES_X, 1'b1);
        endcase
        return e;
    endfunction

    // truncated Q30 arctangent table
    function automatic logic signed [34:0] atan_q30(input logic [TAB_IDX_W-1:0] i);
        logic signed [34:0] v;
        case (i)
            5'd0:  v = 35'sh3243F6A8;
            5'd1:  v = 35'sh1DAC6705;
            5'd2:  v = 35'sh0FADBAFC;
            5'd3:  v = 35'sh07F56EA6;
            5'd4:  v = 35'sh03FEAB76;
            5'd5:  v = 35'sh01FFD55B;
            5'd6:  v = 35'sh00FFFAAA;
            5'd7:  v = 35'sh007FFF55;
            5'd8:  v = 35'sh003FFFEA;
            5'd9:  v = 35'sh001FFFFD;
            5'd10: v = 35'sh000FFFFF;
            5'd11: v = 35'sh0007FFFF;
            5'd12: v = 35'sh0003FFFF;
            5'd13: v = 35'sh0001FFFF;
            5'd14: v = 35'sh0000FFFF;
            5'd15: v = 35'sh00007FFF;
            5'd16: v = 35'sh00003FFF;
            5'd17: v = 35'sh00001FFF;
            5'd18: v = 35'sh00000FFF;
            5'd19: v = 35'sh000007FF;
            5'd20: v = 35'sh000003FF;
            5'd21: v = 35'sh000001FF;
            5'd22: v = 35'sh000000FF;
            5'd23: v = 35'sh0000007F;
            default: v = 35'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
        logic signed [15:0] r;
        if (v > 40'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -40'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/qou_cordic.sv =====
// Iterative rotation-mode CORDIC: half-angle sine and cosine, one step a cycle.
// Depends on qou_pkg (constants, arctangent table).
module qou_cordic (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [15:0] angle,
    output logic               done,
    output logic signed [17:0] sin_out,
    output logic signed [17:0] cos_out
);

    typedef enum logic [1:0] {C_IDLE, C_REDUCE, C_ITER, C_FINISH} cstate_t;

    cstate_t                   state_reg;
    logic signed [34:0]        z_reg;
    logic signed [33:0]        x_reg;
    logic signed [33:0]        y_reg;
    logic                      flip_reg;
    logic [qou_pkg::STEP_W-1:0] i_reg;
    logic                      done_reg;
    logic signed [17:0]        sin_reg;
    logic signed [17:0]        cos_reg;

    logic signed [33:0] dx, dy, xf, yf, xr, yr;
    logic signed [34:0] atan;

    always_comb begin
        dx   = y_reg >>> i_reg;
        dy   = x_reg >>> i_reg;
        atan = qou_pkg::atan_q30(qou_pkg::TAB_IDX_W'(i_reg));
        xf   = flip_reg ? -x_reg : x_reg;
        yf   = flip_reg ? -y_reg : y_reg;
        xr   = (xf + (34'sd1 <<< (qou_pkg::CORD_SHIFT - 1))) >>> qou_pkg::CORD_SHIFT;
        yr   = (yf + (34'sd1 <<< (qou_pkg::CORD_SHIFT - 1))) >>> qou_pkg::CORD_SHIFT;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                C_IDLE: begin
                    if (start) begin
                        z_reg     <= 35'(angle) <<< 17;
                        x_reg     <= qou_pkg::CORDIC_X0;
                        y_reg     <= 34'sd0;
                        flip_reg  <= 1'b0;
                        i_reg     <= '0;
                        state_reg <= C_REDUCE;
                    end
                end
                C_REDUCE: begin
                    // fold the phase into [-pi/2, pi/2], negating on each step
                    if (z_reg > qou_pkg::PHASE_HALF_PI) begin
                        z_reg    <= z_reg - qou_pkg::PHASE_PI;
                        flip_reg <= ~flip_reg;
                    end else if (z_reg < -qou_pkg::PHASE_HALF_PI) begin
                        z_reg    <= z_reg + qou_pkg::PHASE_PI;
                        flip_reg <= ~flip_reg;
                    end else begin
                        state_reg <= C_ITER;
                    end
                end
                C_ITER: begin
                    if (z_reg >= 35'sd0) begin
                        x_reg <= x_reg - dx;
                        y_reg <= y_reg + dy;
                        z_reg <= z_reg - atan;
                    end else begin
                        x_reg <= x_reg + dx;
                        y_reg <= y_reg - dy;
                        z_reg <= z_reg + atan;
                    end
                    i_reg <= i_reg + 1'b1;
                    if (i_reg == qou_pkg::STEP_W'(qou_pkg::CORDIC_STEPS - 1)) begin
                        state_reg <= C_FINISH;
                    end
                end
                C_FINISH: begin
                    cos_reg   <= xr[17:0];
                    sin_reg   <= yr[17:0];
                    done_reg  <= 1'b1;
                    state_reg <= C_IDLE;
                end
                default: begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

    assign done    = done_reg;
    assign sin_out = sin_reg;
    assign cos_out = cos_reg;

endmodule

// ===== rtl/qou_datapath.sv =====
// Datapath: orientation, operand and sine/cosine registers, shared multiply-accumulate.
// Depends on qou_pkg and qou_cordic.
module qou_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  qou_pkg::in_item_t    in_item,
    input  qou_pkg::ctrl_cmd_t   cmd,
    output qou_pkg::dp_status_t  status,
    output qou_pkg::out_item_t   out_item
);

    qou_pkg::in_item_t  item_reg;
    logic signed [15:0] ox_reg, oy_reg, oz_reg, ow_reg;
    logic signed [15:0] rx_reg, ry_reg, rz_reg, rw_reg;
    logic signed [15:0] res_x_reg, res_y_reg, res_z_reg, res_w_reg;
    logic signed [17:0] s_reg [3];
    logic signed [17:0] c_reg [3];
    logic signed [17:0] cpcy_reg, spsy_reg, cpsy_reg, spcy_reg;
    logic signed [35:0] prod_reg;
    logic               pvalid_reg;
    qou_pkg::mac_entry_t pent_reg;
    logic signed [39:0] acc_reg;
    qou_pkg::out_item_t out_reg;

    qou_pkg::mac_entry_t ent;
    logic signed [17:0] op_a, op_b;
    logic signed [15:0] angle_sel;
    logic signed [39:0] sum, rnd;
    logic               cord_done;
    logic signed [17:0] cord_sin, cord_cos;
    logic signed [15:0] s_sat, c_sat;

    function automatic logic signed [17:0] pick(input qou_pkg::src_t sel,
        input logic signed [15:0] ox, input logic signed [15:0] oy,
        input logic signed [15:0] oz, input logic signed [15:0] ow,
        input logic signed [15:0] rx, input logic signed [15:0] ry,
        input logic signed [15:0] rz, input logic signed [15:0] rw,
        input qou_pkg::in_item_t it,
        input logic signed [17:0] s0, input logic signed [17:0] c0,
        input logic signed [17:0] s1, input logic signed [17:0] c1,
        input logic signed [17:0] s2, input logic signed [17:0] c2,
        input logic signed [17:0] p0, input logic signed [17:0] p1,
        input logic signed [17:0] p2, input logic signed [17:0] p3);
        logic signed [17:0] v;
        case (sel)
            qou_pkg::SRC_OX:   v = 18'(ox);
            qou_pkg::SRC_OY:   v = 18'(oy);
            qou_pkg::SRC_OZ:   v = 18'(oz);
            qou_pkg::SRC_OW:   v = 18'(ow);
            qou_pkg::SRC_RX:   v = 18'(rx);
            qou_pkg::SRC_RY:   v = 18'(ry);
            qou_pkg::SRC_RZ:   v = 18'(rz);
            qou_pkg::SRC_RW:   v = 18'(rw);
            qou_pkg::SRC_IX:   v = 18'(it.in_x);
            qou_pkg::SRC_IY:   v = 18'(it.in_y);
            qou_pkg::SRC_IZ:   v = 18'(it.in_z);
            qou_pkg::SRC_IW:   v = 18'(it.in_w);
            qou_pkg::SRC_S0:   v = s0;
            qou_pkg::SRC_C0:   v = c0;
            qou_pkg::SRC_S1:   v = s1;
            qou_pkg::SRC_C1:   v = c1;
            qou_pkg::SRC_S2:   v = s2;
            qou_pkg::SRC_C2:   v = c2;
            qou_pkg::SRC_CPCY: v = p0;
            qou_pkg::SRC_SPSY: v = p1;
            qou_pkg::SRC_CPSY: v = p2;
            qou_pkg::SRC_SPCY: v = p3;
            qou_pkg::SRC_ONE:  v = 18'sd1 <<< qou_pkg::FRAC_BITS;
            default:           v = 18'sd0;
        endcase
        return v;
    endfunction

    always_comb begin
        case (cmd.cord_slot)
            2'd1:    angle_sel = item_reg.angle_b;
            2'd2:    angle_sel = item_reg.angle_c;
            default: angle_sel = item_reg.angle_a;
        endcase
    end

    qou_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.cord_start),
        .angle   (angle_sel),
        .done    (cord_done),
        .sin_out (cord_sin),
        .cos_out (cord_cos)
    );

    always_comb begin
        ent  = qou_pkg::mac_prog(cmd.pc);
        op_a = pick(ent.a_sel, ox_reg, oy_reg, oz_reg, ow_reg, rx_reg, ry_reg, rz_reg,
                    rw_reg, item_reg, s_reg[0], c_reg[0], s_reg[1], c_reg[1], s_reg[2],
                    c_reg[2], cpcy_reg, spsy_reg, cpsy_reg, spcy_reg);
        op_b = pick(ent.b_sel, ox_reg, oy_reg, oz_reg, ow_reg, rx_reg, ry_reg, rz_reg,
                    rw_reg, item_reg, s_reg[0], c_reg[0], s_reg[1], c_reg[1], s_reg[2],
                    c_reg[2], cpcy_reg, spsy_reg, cpsy_reg, spcy_reg);
        sum  = pent_reg.neg ? acc_reg - 40'(prod_reg) : acc_reg + 40'(prod_reg);
        rnd  = (sum + (40'sd1 <<< (qou_pkg::FRAC_BITS - 1))) >>> qou_pkg::FRAC_BITS;
        s_sat = qou_pkg::sat16(40'(s_reg[0]));
        c_sat = qou_pkg::sat16(40'(c_reg[0]));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ox_reg     <= 16'sd0;
            oy_reg     <= 16'sd0;
            oz_reg     <= 16'sd0;
            ow_reg     <= 16'sd16384;
            pvalid_reg <= 1'b0;
            acc_reg    <= 40'sd0;
        end else begin
            if (cmd.load_in) begin
                item_reg <= in_item;
                rx_reg   <= in_item.in_x;
                ry_reg   <= in_item.in_y;
                rz_reg   <= in_item.in_z;
                rw_reg   <= in_item.in_w;
                acc_reg  <= 40'sd0;
            end
            if (cord_done) begin
                s_reg[cmd.cord_slot] <= cord_sin;
                c_reg[cmd.cord_slot] <= cord_cos;
            end
            if (cmd.rot_load) begin
                // axis quaternion: sine on the chosen axis, cosine in w
                rx_reg <= (cmd.rot_axis == 2'd0) ? s_sat : 16'sd0;
                ry_reg <= (cmd.rot_axis == 2'd1) ? s_sat : 16'sd0;
                rz_reg <= (cmd.rot_axis == 2'd2) ? s_sat : 16'sd0;
                rw_reg <= c_sat;
            end

            // stage 1: product
            pvalid_reg <= cmd.mac_issue;
            if (cmd.mac_issue) begin
                prod_reg <= op_a * op_b;
                pent_reg <= ent;
            end

            // stage 2: accumulate, round and write on the last term
            if (pvalid_reg) begin
                if (pent_reg.last) begin
                    acc_reg <= 40'sd0;
                    case (pent_reg.dst)
                        qou_pkg::DST_RES_X: res_x_reg <= qou_pkg::sat16(rnd);
                        qou_pkg::DST_RES_Y: res_y_reg <= qou_pkg::sat16(rnd);
                        qou_pkg::DST_RES_Z: res_z_reg <= qou_pkg::sat16(rnd);
                        qou_pkg::DST_RES_W: res_w_reg <= qou_pkg::sat16(rnd);
                        qou_pkg::DST_CPCY:  cpcy_reg  <= rnd[17:0];
                        qou_pkg::DST_SPSY:  spsy_reg  <= rnd[17:0];
                        qou_pkg::DST_CPSY:  cpsy_reg  <= rnd[17:0];
                        qou_pkg::DST_SPCY:  spcy_reg  <= rnd[17:0];
                        default:            cpcy_reg  <= cpcy_reg;
                    endcase
                end else begin
                    acc_reg <= sum;
                end
            end

            if (cmd.commit) begin
                ox_reg        <= res_x_reg;
                oy_reg        <= res_y_reg;
                oz_reg        <= res_z_reg;
                ow_reg        <= res_w_reg;
                out_reg.out_x <= res_x_reg;
                out_reg.out_y <= res_y_reg;
                out_reg.out_z <= res_z_reg;
                out_reg.out_w <= res_w_reg;
            end
        end
    end

    assign status.cord_done = cord_done;
    assign out_item         = out_reg;

endmodule

// ===== rtl/qou_ctrl.sv =====
// Controller: sequences the CORDIC runs and the multiply-accumulate microprogram.
// Depends on qou_pkg.
module qou_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [2:0]          in_op,
    output logic                m_valid,
    input  logic                m_ready,
    input  qou_pkg::dp_status_t status,
    output qou_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_CORD_START, ST_CORD_WAIT, ST_ROT, ST_MAC, ST_DRAIN, ST_COMMIT
    } state_t;

    state_t                   state_reg;
    logic [2:0]               op_reg;
    logic [1:0]               kidx_reg;
    logic [qou_pkg::PC_W-1:0] pc_reg;
    logic                     m_valid_reg;

    logic accept, out_free, is_rot, needs_cord;
    qou_pkg::mac_entry_t ent;
    logic [qou_pkg::PC_W-1:0] pc_start;
    logic [2:0] rot_idx;

    always_comb begin
        accept     = s_valid && (state_reg == ST_IDLE);
        out_free   = !m_valid_reg || m_ready;
        is_rot     = (op_reg == qou_pkg::OP_ROT_X) || (op_reg == qou_pkg::OP_ROT_Y)
                  || (op_reg == qou_pkg::OP_ROT_Z);
        needs_cord = (in_op == qou_pkg::OP_AXIS) || (in_op == qou_pkg::OP_PYR)
                  || (in_op == qou_pkg::OP_ROT_X) || (in_op == qou_pkg::OP_ROT_Y)
                  || (in_op == qou_pkg::OP_ROT_Z);
        ent        = qou_pkg::mac_prog(pc_reg);
        rot_idx    = op_reg - qou_pkg::OP_ROT_X;
        case (in_op)
            qou_pkg::OP_LOAD:  pc_start = qou_pkg::PC_LOAD;
            qou_pkg::OP_AXIS:  pc_start = qou_pkg::PC_AXIS;
            qou_pkg::OP_PYR:   pc_start = qou_pkg::PC_PYR;
            qou_pkg::OP_ROT_X: pc_start = qou_pkg::PC_MUL;
            qou_pkg::OP_ROT_Y: pc_start = qou_pkg::PC_MUL;
            qou_pkg::OP_ROT_Z: pc_start = qou_pkg::PC_MUL;
            qou_pkg::OP_MUL:   pc_start = qou_pkg::PC_MUL;
            default:           pc_start = qou_pkg::PC_KEEP;
        endcase

        cmd            = '0;
        cmd.load_in    = accept;
        cmd.cord_start = (state_reg == ST_CORD_START);
        cmd.cord_slot  = kidx_reg;
        cmd.rot_load   = (state_reg == ST_ROT);
        cmd.rot_axis   = rot_idx[1:0];
        cmd.mac_issue  = (state_reg == ST_MAC);
        cmd.pc         = pc_reg;
        cmd.commit     = (state_reg == ST_COMMIT) && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            kidx_reg    <= 2'd0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        op_reg    <= in_op;
                        kidx_reg  <= 2'd0;
                        pc_reg    <= pc_start;
                        state_reg <= needs_cord ? ST_CORD_START : ST_MAC;
                    end
                end
                ST_CORD_START: begin
                    state_reg <= ST_CORD_WAIT;
                end
                ST_CORD_WAIT: begin
                    if (status.cord_done) begin
                        if ((op_reg == qou_pkg::OP_PYR) && (kidx_reg != 2'd2)) begin
                            kidx_reg  <= kidx_reg + 2'd1;
                            state_reg <= ST_CORD_START;
                        end else if (is_rot) begin
                            state_reg <= ST_ROT;
                        end else begin
                            state_reg <= ST_MAC;
                        end
                    end
                end
                ST_ROT: begin
                    state_reg <= ST_MAC;
                end
                ST_MAC: begin
                    pc_reg <= pc_reg + 1'b1;
                    if (ent.fin) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    state_reg <= ST_COMMIT;
                end
                ST_COMMIT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

// ===== rtl/quaternion_orientation_unit.sv =====
// Quaternion orientation unit, top level: controller plus datapath.
// Each CORDIC run is at most one phase fold, CORDIC_STEPS steps and a finish; the single shared
// multiplier works each term through a product and an accumulate stage. One item at a time:
// the next input transfer is taken at the earliest in the cycle the result goes valid, also
// while that result is stalled. Reset (aresetn low, synchronous) sets the orientation to
// identity and drops results.
// Depends on qou_pkg, qou_ctrl, qou_datapath, qou_cordic.
module quaternion_orientation_unit (
    input  logic               aclk,
    input  logic               aresetn,
    // input transfer channel
    input  logic               s_valid,
    output logic               s_ready,
    input  qou_pkg::in_item_t  s_data,
    // result transfer channel
    output logic               m_valid,
    input  logic               m_ready,
    output qou_pkg::out_item_t m_data
);

    qou_pkg::ctrl_cmd_t  cmd;
    qou_pkg::dp_status_t status;

    // Sequence each transfer: capture, run CORDIC per angle, run the
    // multiply-accumulate microprogram, then commit into the output register.
    // The next transfer is taken while the previous result still waits.
    qou_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .in_op   (s_data.op),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Hold orientation, operands and intermediate terms; one multiply a cycle.
    qou_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_item  (s_data),
        .cmd      (cmd),
        .status   (status),
        .out_item (m_data)
    );

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the quaternion orientation unit.
// Drives input transfers, predicts each updated quaternion and compares it with the result.
// Depends on qou_pkg and quaternion_orientation_unit from rtl/.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int N_RANDOM    = 1500;
    localparam logic [2:0] OP_UNUSED = 3'd7;

    localparam longint ANG_PI      = 64'sd3373259426;
    localparam longint ANG_HALF_PI = 64'sd1686629713;
    localparam longint CORD_INIT   = 64'sd652032874;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    qou_pkg::in_item_t   s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    qou_pkg::out_item_t  m_data;

    // predicted orientation, kept in step with accepted transfers
    longint              q_x, q_y, q_z, q_w;
    qou_pkg::out_item_t  quat_queue[$];
    int                  mismatches = 0;
    int                  cycles = 0;

    quaternion_orientation_unit i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    // Hard stop: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("quaternion_orientation_unit test failed");
            $finish;
        end
    end

    // Arithmetic shift right and round half up, on 64-bit signed values.
    function automatic longint round_sh(input longint v, input int s);
        if (s <= 0) begin
            return v;
        end
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp16(input longint v);
        if (v > 32767) begin
            return 32767;
        end else if (v < -32768) begin
            return -32768;
        end
        return v;
    endfunction

    function automatic longint arctan_step(input int i);
        longint tab[24] = '{
            64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
            64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
            64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
            64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
            64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
        return tab[i];
    endfunction

    // Sine and cosine of half the Q4.12 angle, in Q2.14.
    task automatic half_angle_sincos(input logic signed [15:0] ang,
                                     output longint s, output longint c);
        longint ph, cx, cy, dx, dy;
        bit     flip;
        ph = longint'(ang) * 131072;
        flip = 1'b0;
        cx = CORD_INIT;
        cy = 0;
        while (ph > ANG_HALF_PI) begin
            ph -= ANG_PI;
            flip = !flip;
        end
        while (ph < -ANG_HALF_PI) begin
            ph += ANG_PI;
            flip = !flip;
        end
        for (int i = 0; i < qou_pkg::CORDIC_STEPS && i < 24; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (ph >= 0) begin
                cx -= dx;
                cy += dy;
                ph -= arctan_step(i);
            end else begin
                cx += dx;
                cy -= dy;
                ph += arctan_step(i);
            end
        end
        if (flip) begin
            cx = -cx;
            cy = -cy;
        end
        c = round_sh(cx, 30 - qou_pkg::FRAC_BITS);
        s = round_sh(cy, 30 - qou_pkg::FRAC_BITS);
    endtask

    // Hamilton product of the orientation with r on the right.
    task automatic hamilton_right(input longint rx, ry, rz, rw);
        longint ox, oy, oz, ow;
        ox = q_x; oy = q_y; oz = q_z; ow = q_w;
        q_w = clamp16(round_sh(ow*rw - ox*rx - oy*ry - oz*rz, qou_pkg::FRAC_BITS));
        q_x = clamp16(round_sh(oy*rz - oz*ry + ow*rx + ox*rw, qou_pkg::FRAC_BITS));
        q_y = clamp16(round_sh(oz*rx - ox*rz + ow*ry + oy*rw, qou_pkg::FRAC_BITS));
        q_z = clamp16(round_sh(ox*ry - oy*rx + ow*rz + oz*rw, qou_pkg::FRAC_BITS));
    endtask

    task automatic predict_orientation(input qou_pkg::in_item_t it);
        longint s0, c0, s1, c1, s2, c2, cpcy, spsy, cpsy, spcy;
        longint ax[3];
        qou_pkg::out_item_t r;
        case (it.op)
            qou_pkg::OP_LOAD: begin
                q_x = it.in_x; q_y = it.in_y; q_z = it.in_z; q_w = it.in_w;
            end
            qou_pkg::OP_AXIS: begin
                half_angle_sincos(it.angle_a, s0, c0);
                q_x = clamp16(round_sh(longint'(it.in_x) * s0, qou_pkg::FRAC_BITS));
                q_y = clamp16(round_sh(longint'(it.in_y) * s0, qou_pkg::FRAC_BITS));
                q_z = clamp16(round_sh(longint'(it.in_z) * s0, qou_pkg::FRAC_BITS));
                q_w = clamp16(c0);
            end
            qou_pkg::OP_PYR: begin
                half_angle_sincos(it.angle_a, s0, c0);
                half_angle_sincos(it.angle_b, s1, c1);
                half_angle_sincos(it.angle_c, s2, c2);
                cpcy = round_sh(c0 * c1, qou_pkg::FRAC_BITS);
                spsy = round_sh(s0 * s1, qou_pkg::FRAC_BITS);
                cpsy = round_sh(c0 * s1, qou_pkg::FRAC_BITS);
                spcy = round_sh(s0 * c1, qou_pkg::FRAC_BITS);
                q_x = clamp16(round_sh(s2*cpcy - c2*spsy, qou_pkg::FRAC_BITS));
                q_y = clamp16(round_sh(c2*spcy + s2*cpsy, qou_pkg::FRAC_BITS));
                q_z = clamp16(round_sh(c2*cpsy - s2*spcy, qou_pkg::FRAC_BITS));
                q_w = clamp16(round_sh(c2*cpcy + s2*spsy, qou_pkg::FRAC_BITS));
            end
            qou_pkg::OP_ROT_X, qou_pkg::OP_ROT_Y, qou_pkg::OP_ROT_Z: begin
                half_angle_sincos(it.angle_a, s0, c0);
                ax = '{0, 0, 0};
                ax[it.op - qou_pkg::OP_ROT_X] = clamp16(s0);
                hamilton_right(ax[0], ax[1], ax[2], clamp16(c0));
            end
            qou_pkg::OP_MUL: begin
                hamilton_right(it.in_x, it.in_y, it.in_z, it.in_w);
            end
            default: ;
        endcase
        r.out_x = q_x[15:0];
        r.out_y = q_y[15:0];
        r.out_z = q_z[15:0];
        r.out_w = q_w[15:0];
        quat_queue.push_back(r);
    endtask

    // Gap length: mostly none or short, now and then long.
    function automatic int idle_len();
        int p;
        p = $urandom_range(99);
        if (p < 50) begin
            return 0;
        end else if (p < 92) begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(60, 10);
    endfunction

    // Hold the transfer until accepted, then predict its result.
    // Valid drops only for a real gap, so back-to-back transfers keep it high.
    task automatic send_item(input qou_pkg::in_item_t it);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        predict_orientation(it);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (quat_queue.size() != 0) @(posedge aclk);
    endtask

    function automatic qou_pkg::in_item_t rand_item(input logic [2:0] op);
        qou_pkg::in_item_t it;
        it.op      = op;
        it.angle_a = 16'($urandom());
        it.angle_b = 16'($urandom());
        it.angle_c = 16'($urandom());
        // keep operands mostly near unit magnitude, with full-range noise sometimes
        it.in_x = ($urandom_range(3) == 0) ? 16'($urandom()) : 16'($urandom_range(32768) - 16384);
        it.in_y = ($urandom_range(3) == 0) ? 16'($urandom()) : 16'($urandom_range(32768) - 16384);
        it.in_z = ($urandom_range(3) == 0) ? 16'($urandom()) : 16'($urandom_range(32768) - 16384);
        it.in_w = ($urandom_range(3) == 0) ? 16'($urandom()) : 16'($urandom_range(32768) - 16384);
        return it;
    endfunction

    function automatic qou_pkg::in_item_t mk_item(input logic [2:0] op,
                                                  input logic signed [15:0] a,
                                                  b, c, x, y, z, w);
        qou_pkg::in_item_t it;
        it = '{op, a, b, c, x, y, z, w};
        return it;
    endfunction

    // Result side: random stalls, compare each transfer with the oldest prediction.
    always @(posedge aclk) begin
        qou_pkg::out_item_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (quat_queue.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10) begin
                        $display("unexpected result %h", m_data);
                    end
                end else begin
                    want = quat_queue.pop_front();
                    if (want !== m_data) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10) begin
                            $display("quat mismatch: exp x=%0d y=%0d z=%0d w=%0d",
                                     want.out_x, want.out_y, want.out_z, want.out_w);
                            $display("               got x=%0d y=%0d z=%0d w=%0d",
                                     m_data.out_x, m_data.out_y, m_data.out_z, m_data.out_w);
                        end
                    end
                end
            end
            m_ready <= ($urandom_range(99) < 8) ? 1'b0 : ($urandom_range(99) < 75);
        end
    end

    // Extremes of the fields (angle_c only at its top), every op, the unused op and saturation.
    task automatic test_directed();
        send_item(mk_item(OP_UNUSED, 0, 0, 0, 0, 0, 0, 0));
        send_item(mk_item(qou_pkg::OP_LOAD, 0, 0, 0, 16'sh7FFF, 16'sh8000, 16'sh7FFF,
                          16'sh8000));
        send_item(mk_item(qou_pkg::OP_MUL, 0, 0, 0, 16'sh7FFF, 16'sh7FFF, 16'sh8000,
                          16'sh7FFF));
        send_item(mk_item(OP_UNUSED, 16'sh7FFF, 16'sh8000, 0, -1, -1, -1, -1));
        send_item(mk_item(qou_pkg::OP_AXIS, 16'sh7FFF, 0, 0, 16'sh7FFF, 16'sh8000,
                          16'sd16384, 0));
        send_item(mk_item(qou_pkg::OP_AXIS, 16'sh8000, 0, 0, 16'sh8000, 16'sh7FFF,
                          -16'sd16384, 0));
        send_item(mk_item(qou_pkg::OP_AXIS, 0, 0, 0, 16'sd16384, 0, 0, 0));
        send_item(mk_item(qou_pkg::OP_PYR, 16'sh7FFF, 16'sh8000, 0, 0, 0, 0, 0));
        send_item(mk_item(qou_pkg::OP_PYR, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 0, 0, 0, 0));
        send_item(mk_item(qou_pkg::OP_PYR, 16'sd6434, -16'sd6434, 16'sd12868, 0, 0, 0, 0));
        send_item(mk_item(qou_pkg::OP_ROT_X, 16'sh7FFF, 0, 0, 0, 0, 0, 0));
        send_item(mk_item(qou_pkg::OP_ROT_Y, 16'sh8000, 0, 0, 0, 0, 0, 0));
        send_item(mk_item(qou_pkg::OP_ROT_Z, 16'sd6434, 0, 0, 0, 0, 0, 0));
        send_item(mk_item(qou_pkg::OP_ROT_X, 16'sd12868, 0, 0, 0, 0, 0, 0));
        send_item(mk_item(qou_pkg::OP_LOAD, 0, 0, 0, 16'sh8000, 16'sh8000, 16'sh8000,
                          16'sh8000));
        send_item(mk_item(qou_pkg::OP_MUL, 0, 0, 0, 16'sh8000, 16'sh8000, 16'sh8000,
                          16'sh8000));
        send_item(mk_item(qou_pkg::OP_LOAD, 0, 0, 0, 0, 0, 0, 16'sd16384));
        // hold off until the unit has caught up completely
        wait_drained();
        send_item(mk_item(qou_pkg::OP_MUL, 0, 0, 0, 16'sd11585, 0, 0, 16'sd11585));
    endtask

    // Random sequences: mostly rotations and products on a sane orientation.
    task automatic test_random();
        logic [2:0] op;
        for (int n = 0; n < N_RANDOM; n++) begin
            case ($urandom_range(15))
                0:       op = qou_pkg::OP_LOAD;
                1, 2:    op = qou_pkg::OP_AXIS;
                3, 4:    op = qou_pkg::OP_PYR;
                5, 6:    op = qou_pkg::OP_ROT_X;
                7, 8:    op = qou_pkg::OP_ROT_Y;
                9, 10:   op = qou_pkg::OP_ROT_Z;
                11, 12:  op = qou_pkg::OP_MUL;
                13:      op = OP_UNUSED;
                default: op = 3'($urandom_range(7));
            endcase
            send_item(rand_item(op));
            if (n % 400 == 399) begin
                wait_drained();
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        q_x = 0; q_y = 0; q_z = 0; q_w = 16384;
        @(posedge aclk);
        test_directed();
        test_random();
        wait_drained();
        repeat (200) @(posedge aclk);
        if (mismatches == 0 && quat_queue.size() == 0) begin
            $display("quaternion_orientation_unit test passed");
        end else begin
            $display("quaternion_orientation_unit test failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/qou_pkg.sv
rtl/qou_cordic.sv
rtl/qou_datapath.sv
rtl/qou_ctrl.sv
rtl/quaternion_orientation_unit.sv
test/tb_top.sv
